FILE: design/range_gated_point_centroid_assert.svh
// ----------------------------------------------------------------------------
// range_gated_point_centroid_assert.svh
// assertion macros used by the range gated centroid controller
// ----------------------------------------------------------------------------
`ifndef RANGE_GATED_POINT_CENTROID_ASSERT_SVH
`define RANGE_GATED_POINT_CENTROID_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RGPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgpc: same-cycle check failed");

// next-cycle implication, checked on every rising edge outside reset
`define RGPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgpc: next-cycle check failed");

`endif

FILE: design/rgpc_pkg.sv
// ----------------------------------------------------------------------------
// rgpc_pkg
// types, widths and constants of the range gated point centroid
// ----------------------------------------------------------------------------
package rgpc_pkg;

  // field widths
  localparam int COORD_W   = 20;
  localparam int LIMIT_W   = 19;
  localparam int OFFSET_W  = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  // default frame capacity
  localparam int MAX_POINTS_DEF = 524288;

  // register reset values
  localparam logic [LIMIT_W-1:0]         NEAR_RESET     = LIMIT_W'(10000);
  localparam logic [LIMIT_W-1:0]         FAR_RESET      = LIMIT_W'(11000);
  localparam logic signed [OFFSET_W-1:0] OFFSET_X_RESET = OFFSET_W'(140);
  localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RESET = OFFSET_W'(79);

  // start value of the running minimum depth (10 m)
  localparam logic signed [COORD_W-1:0] LEAST_Z_START = COORD_W'(100000);

  // output clamp limits
  localparam int OUT_MAX     = 2 ** (COORD_W - 1) - 1;
  localparam int OUT_MIN     = -(2 ** (COORD_W - 1));
  localparam int CNT_OUT_MAX = 2 ** COORD_W - 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_LIMIT = 2'd0,
    REG_FAR_LIMIT  = 2'd1,
    REG_OFFSET_X   = 2'd2,
    REG_OFFSET_Y   = 2'd3
  } rgpc_reg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic accumulate;
    logic frame_clear;
    logic div_start;
    logic div_step;
    logic out_load;
  } rgpc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic count_zero;
  } rgpc_status_t;

endpackage

FILE: design/rgpc_if.sv
// ----------------------------------------------------------------------------
// rgpc_if
// valid/ready channels for input points and frame results
// ----------------------------------------------------------------------------
interface rgpc_point_if;
  import rgpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic                      last;

  modport source (output valid, point_x, point_y, point_z, last, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last, output ready);
endinterface

interface rgpc_result_if;
  import rgpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [COORD_W-1:0] min_depth;
  logic [COORD_W-1:0]        point_count;

  modport source (output valid, pos_x, pos_y, pos_z, min_depth, point_count, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, min_depth, point_count, output ready);
endinterface

FILE: design/rgpc_datapath.sv
// ----------------------------------------------------------------------------
// rgpc_datapath
// squaring, range gate, frame sums, three-lane divider and result register
// ----------------------------------------------------------------------------
module rgpc_datapath #(
  parameter int MAX_POINTS = rgpc_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                wr_en,
  input  logic [rgpc_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [rgpc_pkg::CFG_DATA_W-1:0]     wr_data,
  // input point
  input  logic signed [rgpc_pkg::COORD_W-1:0] point_x,
  input  logic signed [rgpc_pkg::COORD_W-1:0] point_y,
  input  logic signed [rgpc_pkg::COORD_W-1:0] point_z,
  input  logic                                last,
  // control
  input  rgpc_pkg::rgpc_cmd_t                 cmd,
  output rgpc_pkg::rgpc_status_t              status,
  // result payload
  output logic signed [rgpc_pkg::COORD_W-1:0] pos_x,
  output logic signed [rgpc_pkg::COORD_W-1:0] pos_y,
  output logic signed [rgpc_pkg::COORD_W-1:0] pos_z,
  output logic signed [rgpc_pkg::COORD_W-1:0] min_depth,
  output logic [rgpc_pkg::COORD_W-1:0]        point_count
);
  import rgpc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ACC_W  = COORD_W + CNT_W;
  localparam int PROD_W = 2 * COORD_W;
  localparam int SQ_W   = 2 * COORD_W - 1;
  localparam int D2_W   = SQ_W + 1;
  localparam int LSQ_W  = 2 * LIMIT_W;
  localparam int MEAN_W = COORD_W + 1;
  localparam int SUM_W  = COORD_W + 2;

  // configuration registers
  logic [LIMIT_W-1:0]         near_limit;
  logic [LIMIT_W-1:0]         far_limit;
  logic signed [OFFSET_W-1:0] offset_x;
  logic signed [OFFSET_W-1:0] offset_y;

  // squared limits
  logic [LSQ_W-1:0] near_sq;
  logic [LSQ_W-1:0] far_sq;

  // full-width squares, latched point and its squares
  logic signed [PROD_W-1:0]  prod [3];
  logic signed [COORD_W-1:0] pt_q [3];
  logic [SQ_W-1:0]           sq_q [3];
  logic                      last_q;

  // frame state
  logic signed [ACC_W-1:0]   acc [3];
  logic [CNT_W-1:0]          kept_count;
  logic signed [COORD_W-1:0] least_z;

  // divider lanes
  logic [ACC_W-1:0]          dvd [3];
  logic [CNT_W-1:0]          rem [3];
  logic                      neg [3];
  logic [CNT_W-1:0]          divisor;
  logic signed [COORD_W-1:0] frame_min;
  logic [CNT_W-1:0]          frame_cnt;

  // result register
  logic signed [COORD_W-1:0] pos_q [3];
  logic signed [COORD_W-1:0] min_q;
  logic [COORD_W-1:0]        cnt_q;

  logic [D2_W-1:0]           d2;
  logic                      keep;
  logic [CNT_W:0]            trial [3];
  logic                      ge [3];
  logic [CNT_W:0]            diff [3];
  logic signed [MEAN_W-1:0]  mean [3];
  logic signed [SUM_W-1:0]   off [3];
  logic signed [SUM_W-1:0]   biased [3];
  logic signed [COORD_W-1:0] clamped [3];
  logic [COORD_W-1:0]        cnt_sat;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= NEAR_RESET;
      far_limit  <= FAR_RESET;
      offset_x   <= OFFSET_X_RESET;
      offset_y   <= OFFSET_Y_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_NEAR_LIMIT: near_limit <= wr_data;
        REG_FAR_LIMIT:  far_limit  <= wr_data;
        REG_OFFSET_X:   offset_x   <= wr_data[OFFSET_W-1:0];
        REG_OFFSET_Y:   offset_y   <= wr_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // squared band limits, refreshed every cycle
  always_ff @(posedge clk) begin
    near_sq <= near_limit * near_limit;
    far_sq  <= far_limit * far_limit;
  end

  // signed squares of the incoming point at full product width
  always_comb begin
    prod[0] = point_x * point_x;
    prod[1] = point_y * point_y;
    prod[2] = point_z * point_z;
  end

  // latch the point and its squares
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_q[0] <= point_x;
      pt_q[1] <= point_y;
      pt_q[2] <= point_z;
      sq_q[0] <= prod[0][SQ_W-1:0];
      sq_q[1] <= prod[1][SQ_W-1:0];
      sq_q[2] <= prod[2][SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_q <= 1'b0;
    end else if (cmd.load) begin
      last_q <= last;
    end
  end

  // range gate
  always_comb begin
    d2   = D2_W'(sq_q[0]) + D2_W'(sq_q[1]) + D2_W'(sq_q[2]);
    keep = (d2 >= D2_W'(near_sq)) && (d2 <= D2_W'(far_sq)) &&
           (32'(kept_count) < 32'(MAX_POINTS));
  end

  // frame sums, count and least depth
  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= '0;
      end
      kept_count <= '0;
      least_z    <= LEAST_Z_START;
    end else if (cmd.accumulate && keep) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= acc[i] + ACC_W'(pt_q[i]);
      end
      kept_count <= kept_count + CNT_W'(1);
      if (pt_q[2] < least_z) begin
        least_z <= pt_q[2];
      end
    end
  end

  // one restoring division step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem[i], dvd[i][ACC_W-1]};
      ge[i]    = trial[i] >= {1'b0, divisor};
      diff[i]  = trial[i] - {1'b0, divisor};
    end
  end

  // divider lanes: load magnitudes, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= acc[i][ACC_W-1];
        dvd[i] <= acc[i][ACC_W-1] ? ACC_W'(-acc[i]) : ACC_W'(acc[i]);
        rem[i] <= '0;
      end
      divisor   <= kept_count;
      frame_min <= least_z;
      frame_cnt <= kept_count;
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        rem[i] <= ge[i] ? diff[i][CNT_W-1:0] : trial[i][CNT_W-1:0];
        dvd[i] <= {dvd[i][ACC_W-2:0], ge[i]};
      end
    end
  end

  // signed means plus the x and y offsets, clamped to the output range; count saturated
  always_comb begin
    off[0] = SUM_W'(offset_x);
    off[1] = SUM_W'(offset_y);
    off[2] = '0;
    for (int i = 0; i < 3; i++) begin
      mean[i]   = neg[i] ? -$signed(dvd[i][MEAN_W-1:0]) : $signed(dvd[i][MEAN_W-1:0]);
      biased[i] = SUM_W'(mean[i]) + off[i];
      if (biased[i] > SUM_W'(OUT_MAX)) begin
        clamped[i] = COORD_W'(OUT_MAX);
      end else if (biased[i] < SUM_W'(OUT_MIN)) begin
        clamped[i] = COORD_W'(OUT_MIN);
      end else begin
        clamped[i] = biased[i][COORD_W-1:0];
      end
    end
    if (32'(frame_cnt) > 32'(CNT_OUT_MAX)) begin
      cnt_sat = COORD_W'(CNT_OUT_MAX);
    end else begin
      cnt_sat = COORD_W'(frame_cnt);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= clamped[i];
      end
      min_q <= frame_min;
      cnt_q <= cnt_sat;
    end
  end

  assign pos_x       = pos_q[0];
  assign pos_y       = pos_q[1];
  assign pos_z       = pos_q[2];
  assign min_depth   = min_q;
  assign point_count = cnt_q;

  assign status.last       = last_q;
  assign status.count_zero = (kept_count == '0);

endmodule

FILE: design/rgpc_ctrl.sv
// ----------------------------------------------------------------------------
// rgpc_ctrl
// sequencer for point intake, frame close, division and result hand-off
// ----------------------------------------------------------------------------
`include "range_gated_point_centroid_assert.svh"

module rgpc_ctrl #(
  parameter int MAX_POINTS = rgpc_pkg::MAX_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  rgpc_pkg::rgpc_status_t status,
  output rgpc_pkg::rgpc_cmd_t    cmd
);
  import rgpc_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int ACC_W = COORD_W + CNT_W;
  localparam int CYC_W = $clog2(ACC_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_FIN,
    S_DIV,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CYC_W-1:0] div_cnt;
  logic             in_acc;
  logic             out_free;

  // intake is open while idle and while a non-final point accumulates
  always_comb begin
    in_ready = !rst && ((state == S_IDLE) || ((state == S_ACC) && !status.last));
    in_acc   = in_valid && in_ready;
    out_free = !out_valid || out_ready;
  end

  // datapath commands
  always_comb begin
    cmd.load        = in_acc;
    cmd.accumulate  = (state == S_ACC);
    cmd.frame_clear = (state == S_FIN);
    cmd.div_start   = (state == S_FIN) && !status.count_zero;
    cmd.div_step    = (state == S_DIV);
    cmd.out_load    = (state == S_EMIT) && out_free;
  end

  // state, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (status.last) begin
            state <= S_FIN;
          end else if (!in_acc) begin
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          if (status.count_zero) begin
            state <= S_IDLE;
          end else begin
            state   <= S_DIV;
            div_cnt <= CYC_W'(ACC_W - 1);
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_EMIT;
          end else begin
            div_cnt <= div_cnt - CYC_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted point is always gated in the following cycle
  `RGPC_ASSERT_NEXT(a_accept_gates, clk, rst, in_acc, state == S_ACC)
  // a frame with kept points always goes on to division
  `RGPC_ASSERT_NEXT(a_fin_divides, clk, rst, (state == S_FIN) && !status.count_zero, state == S_DIV)
  // the last division step hands over to the result stage
  `RGPC_ASSERT_NEXT(a_div_ends, clk, rst, (state == S_DIV) && (div_cnt == '0), state == S_EMIT)
  // a pending result holds off the next one until it is taken
  `RGPC_ASSERT_NEXT(a_emit_waits, clk, rst, (state == S_EMIT) && out_valid && !out_ready, state == S_EMIT)

endmodule

FILE: design/range_gated_point_centroid.sv
// ----------------------------------------------------------------------------
// range_gated_point_centroid
// range gated centroid and minimum depth of one frame of 3-D points
// ----------------------------------------------------------------------------
// usage
// - points: one point per transaction (x, y, z in 0.1 mm, two's complement),
//   last marks the final point of a frame
// - results: one transaction per frame with at least one point inside the
//   band [near_limit^2, far_limit^2]; an empty frame gives nothing
// - wr_en/wr_index/wr_data: near_limit, far_limit, offset_x, offset_y,
//   written between frames; a limit write applies to points from the next cycle
// - throughput: non-final points are taken at one per cycle, points may stream
//   back to back with or without gaps between them
// - frame close: the final point is followed by the gate state, the close
//   state, then the division over ACC_W = 20 + clog2(MAX_POINTS + 1) quotient
//   bits (40 at the default) in three restoring divider lanes that share one
//   divisor and step together, then the result state; an empty frame skips
//   the division and result; no points are taken during that time
// - a stalled receiver holds the result register; the next frame's points are
//   still taken until its own final point needs the register
// - reset: limits and offsets return to defaults, frame sums cleared,
//   no result pending, no point taken while reset is high
// ----------------------------------------------------------------------------
module range_gated_point_centroid #(
  parameter int MAX_POINTS = rgpc_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [rgpc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rgpc_pkg::CFG_DATA_W-1:0] wr_data,
  rgpc_point_if.sink                      points,
  rgpc_result_if.source                   results
);
  import rgpc_pkg::*;

  rgpc_cmd_t    cmd;
  rgpc_status_t status;

  // sequencer
  rgpc_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and result register
  rgpc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .point_x     (points.point_x),
    .point_y     (points.point_y),
    .point_z     (points.point_z),
    .last        (points.last),
    .cmd         (cmd),
    .status      (status),
    .pos_x       (results.pos_x),
    .pos_y       (results.pos_y),
    .pos_z       (results.pos_z),
    .min_depth   (results.min_depth),
    .point_count (results.point_count)
  );

endmodule
